// ----- rtl/core/tsh_pkg.sv -----
package tsh_pkg;

	localparam int AddrW     = 32;
	localparam int PortW     = 16;
	localparam int WordW     = 32;
	localparam int IdxW      = 4;
	localparam int CfgIdxW   = 8;
	localparam int CfgDataW  = 32;
	localparam int SumW      = 19;
	localparam int HdrWords  = 10;
	localparam int QueueDepthDefault = 2;

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgSourceAddr = 8'd0;
	localparam logic [CfgIdxW-1:0] CfgSourcePort = 8'd1;

	localparam logic [AddrW-1:0] SourceAddrReset = 32'h0000_0000;
	localparam logic [PortW-1:0] SourcePortReset = 16'd64321;

	// fixed header words
	localparam logic [WordW-1:0] Word0Fixed = 32'h4500_0028; // ver 4, ihl 5, len 40
	localparam logic [WordW-1:0] Word2Fixed = 32'hFF06_0000; // ttl 255, proto 6, csum 0
	localparam logic [PortW-1:0] OffsFlags  = 16'h5002;      // doff 5, SYN
	localparam logic [PortW-1:0] TcpWindow  = 16'hFFFF;
	localparam logic [WordW-1:0] Word8Fixed = {OffsFlags, TcpWindow};

	// proto 6 + tcp length 20 + offs/flags + window, folded into the sum
	localparam logic [SumW-1:0] SumConst = 19'h1501B;

	localparam logic [IdxW-1:0] LastIdx = 4'd9;

	typedef struct packed {
		logic [AddrW-1:0] source_addr;
		logic [AddrW-1:0] dest_addr;
		logic [PortW-1:0] source_port;
		logic [PortW-1:0] dest_port;
		logic [PortW-1:0] csum;
	} desc_t;

	typedef struct packed {
		logic push;
	} q_wr_t;

	typedef struct packed {
		logic empty;
	} q_rd_t;

	function automatic logic [WordW-1:0] build_word(desc_t d, logic [IdxW-1:0] idx);
		logic [WordW-1:0] w;
		unique case (idx)
			4'd0:    w = Word0Fixed;
			4'd1:    w = '0;
			4'd2:    w = Word2Fixed;
			4'd3:    w = d.source_addr;
			4'd4:    w = d.dest_addr;
			4'd5:    w = {d.source_port, d.dest_port};
			4'd6:    w = '0;
			4'd7:    w = '0;
			4'd8:    w = Word8Fixed;
			4'd9:    w = {d.csum, 16'h0000};
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/tsh_if.sv -----
interface tsh_probe_if;
	logic                     valid;
	logic                     ready;
	logic [tsh_pkg::AddrW-1:0] dest_addr;
	logic [tsh_pkg::PortW-1:0] dest_port;

	modport source (output valid, dest_addr, dest_port, input ready);
	modport sink   (input valid, dest_addr, dest_port, output ready);
endinterface

interface tsh_hdr_if;
	logic                     valid;
	logic                     ready;
	logic [tsh_pkg::IdxW-1:0]  word_index;
	logic [tsh_pkg::WordW-1:0] header_word;
	logic                     last;

	modport source (output valid, word_index, header_word, last, input ready);
	modport sink   (input valid, word_index, header_word, last, output ready);
endinterface

interface tsh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tsh_pkg::CfgIdxW-1:0]  index;
	logic [tsh_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/tsh_front.sv -----
module tsh_front (
	input  logic          clk,
	input  logic          arst_n,
	tsh_cfg_if.sink       cfg,
	tsh_probe_if.sink     probe,
	output tsh_pkg::desc_t q_data,
	output logic          q_push,
	input  logic          q_full
);
	import tsh_pkg::*;

	logic [AddrW-1:0] source_addr_q;
	logic [PortW-1:0] source_port_q;

	logic             valid_s1;
	logic [AddrW-1:0] saddr_s1;
	logic [AddrW-1:0] daddr_s1;
	logic [PortW-1:0] sport_s1;
	logic [PortW-1:0] dport_s1;
	logic [SumW-1:0]  psum_s1;

	logic             accept;
	logic [SumW-1:0]  psum;
	logic [16:0]      fold1;
	logic [15:0]      fold2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_addr_q <= SourceAddrReset;
			source_port_q <= SourcePortReset;
		end else if (cfg.valid) begin
			if (cfg.index == CfgSourceAddr) begin
				source_addr_q <= cfg.data;
			end else if (cfg.index == CfgSourcePort) begin
				source_port_q <= cfg.data[PortW-1:0];
			end
		end
	end

	assign probe.ready = !valid_s1 || !q_full;
	assign accept      = probe.valid && probe.ready;
	assign q_push      = valid_s1 && !q_full;

	// pseudo header + tcp header partial sum, 16-bit words
	assign psum = SumConst
		+ SumW'(source_addr_q[31:16]) + SumW'(source_addr_q[15:0])
		+ SumW'(probe.dest_addr[31:16]) + SumW'(probe.dest_addr[15:0])
		+ SumW'(source_port_q) + SumW'(probe.dest_port);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			saddr_s1 <= source_addr_q;
			sport_s1 <= source_port_q;
			daddr_s1 <= probe.dest_addr;
			dport_s1 <= probe.dest_port;
			psum_s1  <= psum;
		end
	end

	// end-around carry, twice; the second add cannot carry out
	assign fold1 = 17'(psum_s1[15:0]) + 17'(psum_s1[SumW-1:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	always_comb begin
		q_data.source_addr = saddr_s1;
		q_data.dest_addr   = daddr_s1;
		q_data.source_port = sport_s1;
		q_data.dest_port   = dport_s1;
		q_data.csum        = ~fold2;
	end

endmodule

// ----- rtl/core/tsh_queue.sv -----
module tsh_queue #(
	parameter int DEPTH = tsh_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsh_pkg::desc_t wr_data,
	input  tsh_pkg::q_wr_t wr,
	output logic           full,
	output tsh_pkg::desc_t rd_data,
	input  logic           pop,
	output tsh_pkg::q_rd_t rd
);
	import tsh_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	desc_t           mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CntFull);
	assign rd.empty = (count_q == '0);
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && !rd.empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/tsh_back.sv -----
module tsh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tsh_pkg::desc_t q_data,
	input  tsh_pkg::q_rd_t q_rd,
	output logic           q_pop,
	tsh_hdr_if.source      hdr
);
	import tsh_pkg::*;

	logic [IdxW-1:0]  idx_q;
	logic             out_valid_q;
	logic [IdxW-1:0]  out_index_q;
	logic [WordW-1:0] out_word_q;
	logic             out_last_q;
	logic             load;

	// output slot free or draining this cycle, and a header is waiting
	assign load  = (!out_valid_q || hdr.ready) && !q_rd.empty;
	assign q_pop = load && (idx_q == LastIdx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (hdr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_index_q <= idx_q;
			out_word_q  <= build_word(q_data, idx_q);
			out_last_q  <= (idx_q == LastIdx);
		end
	end

	assign hdr.valid       = out_valid_q;
	assign hdr.word_index  = out_index_q;
	assign hdr.header_word = out_word_q;
	assign hdr.last        = out_last_q;

endmodule

// ----- rtl/core/tcp_syn_header_builder.sv -----
// TCP SYN header builder. Each probe transaction (dest_addr, dest_port) yields the
// 40-byte IPv4 + TCP SYN header as ten 32-bit big-endian words on the hdr channel,
// word_index 0..9, last set on word 9. Source address and port come from the cfg
// channel (index 0: source_addr, index 1: source_port, others ignored); write them
// only while no header is in flight. The TCP checksum covers the pseudo header and
// TCP header; the IP header checksum is sent as zero. The output carries one 32-bit
// word per cycle while hdr.ready is high, and queued headers stream back-to-back
// with no gap. After a probe is accepted, its descriptor passes through the checksum
// stage, then the queue, then the output register, which offers word 0. The probe
// side keeps accepting while the output stalls, until the checksum stage and the
// QUEUE_DEPTH-entry queue fill.
module tcp_syn_header_builder #(
	parameter int QUEUE_DEPTH = tsh_pkg::QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	tsh_cfg_if.sink   cfg,
	tsh_probe_if.sink probe,
	tsh_hdr_if.source hdr
);
	import tsh_pkg::*;

	desc_t front_desc;
	desc_t queue_desc;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_push;
	logic  q_full;
	logic  q_pop;

	assign q_wr.push = q_push;

	// front: config registers, probe intake, checksum
	tsh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.probe  (probe),
		.q_data (front_desc),
		.q_push (q_push),
		.q_full (q_full)
	);

	// header descriptors waiting for serialization
	tsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (front_desc),
		.wr      (q_wr),
		.full    (q_full),
		.rd_data (queue_desc),
		.pop     (q_pop),
		.rd      (q_rd)
	);

	// back: word serializer with registered output
	tsh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (queue_desc),
		.q_rd   (q_rd),
		.q_pop  (q_pop),
		.hdr    (hdr)
	);

endmodule
